@@ rtl/core/b64d_pkg.sv @@
`timescale 1ns / 1ps

package b64d_pkg;

   // Depth of the group queue between the front and the back.
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // One complete group, or one length error, passed from front to back.
   typedef struct packed {
      logic [23:0] triple;
      logic [1:0]  count;
      logic        fin;
      logic        lerr;
      logic        bad;
   } b64d_cmd_type;

   typedef struct packed {
      logic       bad;
      logic [5:0] sextet;
   } b64d_sextet_type;

   // Map one character to its sextet; pad gives zero, anything else outside
   // the alphabet gives zero and raises bad.
   function automatic b64d_sextet_type decode_char(input logic [7:0] c);
      b64d_sextet_type r;
      r.bad    = 1'b0;
      r.sextet = '0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r.sextet = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r.sextet = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r.sextet = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         r.sextet = 6'd62;
      end else if (c == 8'h2F) begin
         r.sextet = 6'd63;
      end else if (c != PAD_CHAR) begin
         r.bad = 1'b1;
      end
      return r;
   endfunction

endpackage

@@ rtl/core/base64_stream_decoder.sv @@
`timescale 1ns / 1ps

// Channel   Ports                                          Handshake
// request   req_in_char, req_final_char                    req_push / req_full
// result    rsp_out_byte, rsp_group_last, rsp_message_end, rsp_empty / rsp_pop
//           rsp_length_error, rsp_bad_char
//
// One request is taken every cycle while req_full is low; the front decodes it
// in the cycle it arrives. A complete group (or a length error) enters the group
// queue and the back drains it at one result per cycle while rsp_pop takes them;
// each byte of a group leaves in turn through the output register.
// Reset is synchronous and empties the queue and the output register.
// req_full rises only when the group queue is full; results held by rsp_pop stall
// the back, and the queue absorbs groups until it fills.

module base64_stream_decoder #(
   parameter int unsigned QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_char,
   input  logic       req_final_char,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_group_last,
   output logic       rsp_message_end,
   output logic       rsp_length_error,
   output logic       rsp_bad_char
);

   b64d_pkg::b64d_cmd_type cmd_data;
   b64d_pkg::b64d_cmd_type head;
   logic                   cmd_push;
   logic                   q_full;
   logic                   q_empty;
   logic                   q_pop;

   // hold requests off only while the group queue has no room
   assign req_full = q_full;

   b64d_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (q_full),
      .req_in_char    (req_in_char),
      .req_final_char (req_final_char),
      .cmd_push       (cmd_push),
      .cmd_data       (cmd_data)
   );

   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (head),
      .empty     (q_empty)
   );

   // advance through the bytes of each queued group, one per cycle while results are taken
   b64d_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_group_last   (rsp_group_last),
      .rsp_message_end  (rsp_message_end),
      .rsp_length_error (rsp_length_error),
      .rsp_bad_char     (rsp_bad_char),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop)
   );

endmodule

@@ rtl/core/b64d_front.sv @@
`timescale 1ns / 1ps

module b64d_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic                   req_full,
   input  logic [7:0]             req_in_char,
   input  logic                   req_final_char,
   output logic                   cmd_push,
   output b64d_pkg::b64d_cmd_type cmd_data
);

   logic [1:0]  pos_ff, pos_in;
   logic [17:0] acc_ff, acc_in;
   logic        third_pad_ff, third_pad_in;
   logic        bad_ff, bad_in;

   logic                      accept;
   logic                      is_pad;
   logic                      bad_now;
   logic                      fin_pad;
   logic                      fin_third;
   b64d_pkg::b64d_sextet_type dec;

   assign accept    = req_push & ~req_full;
   assign dec       = b64d_pkg::decode_char(req_in_char);
   assign is_pad    = (req_in_char == b64d_pkg::PAD_CHAR);
   assign bad_now   = bad_ff | dec.bad;
   assign fin_pad   = req_final_char & is_pad;
   assign fin_third = req_final_char & third_pad_ff;

   always_comb begin
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      third_pad_in = third_pad_ff;
      bad_in       = bad_ff;
      cmd_push     = 1'b0;
      cmd_data     = '0;
      if (accept) begin
         if (pos_ff != 2'd3) begin
            if (req_final_char) begin
               // short message: one error result, drop the partial group
               cmd_push      = 1'b1;
               cmd_data.count = 2'd1;
               cmd_data.fin  = 1'b1;
               cmd_data.lerr = 1'b1;
               cmd_data.bad  = bad_now;
               pos_in        = '0;
               acc_in        = '0;
               third_pad_in  = 1'b0;
               bad_in        = 1'b0;
            end else begin
               acc_in = {acc_ff[11:0], dec.sextet};
               if (pos_ff == 2'd2) begin
                  third_pad_in = is_pad;
               end
               pos_in = pos_ff + 2'd1;
               bad_in = bad_now;
            end
         end else begin
            cmd_push        = 1'b1;
            cmd_data.triple = {acc_ff, dec.sextet};
            cmd_data.count  = 2'd3 - {1'b0, fin_pad} - {1'b0, fin_third};
            cmd_data.fin    = req_final_char;
            cmd_data.lerr   = 1'b0;
            cmd_data.bad    = bad_now;
            pos_in          = '0;
            acc_in          = '0;
            third_pad_in    = 1'b0;
            bad_in          = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         acc_ff       <= '0;
         third_pad_ff <= 1'b0;
         bad_ff       <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         acc_ff       <= acc_in;
         third_pad_ff <= third_pad_in;
         bad_ff       <= bad_in;
      end
   end

endmodule

@@ rtl/core/b64d_queue.sv @@
`timescale 1ns / 1ps

module b64d_queue #(
   parameter int unsigned DEPTH = b64d_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  b64d_pkg::b64d_cmd_type push_data,
   output logic                   full,
   input  logic                   pop,
   output b64d_pkg::b64d_cmd_type head,
   output logic                   empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   b64d_pkg::b64d_cmd_type mem_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (fill_ff == CNT_W'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

@@ rtl/core/b64d_back.sv @@
`timescale 1ns / 1ps

module b64d_back (
   input  logic                   clock,
   input  logic                   reset,
   input  b64d_pkg::b64d_cmd_type head,
   input  logic                   q_empty,
   output logic                   q_pop,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_group_last,
   output logic                   rsp_message_end,
   output logic                   rsp_length_error,
   output logic                   rsp_bad_char,
   output logic                   rsp_empty,
   input  logic                   rsp_pop
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff, end_ff, lerr_ff, bad_ff;

   logic       load;
   logic       last;
   logic [7:0] sel_byte;

   // load the output register whenever a group waits and the register is free or being taken
   assign load = ~q_empty & (~valid_ff | rsp_pop);
   assign last = (idx_ff == head.count - 2'd1);

   always_comb begin
      unique case (idx_ff)
         2'd0:    sel_byte = head.triple[23:16];
         2'd1:    sel_byte = head.triple[15:8];
         default: sel_byte = head.triple[7:0];
      endcase
   end

   always_comb begin
      q_pop    = load & last;
      idx_in   = idx_ff;
      valid_in = valid_ff & ~rsp_pop;
      if (load) begin
         idx_in   = last ? 2'd0 : idx_ff + 2'd1;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= sel_byte;
         last_ff <= last;
         end_ff  <= last & head.fin;
         lerr_ff <= head.lerr;
         bad_ff  <= head.bad;
      end
   end

   assign rsp_out_byte     = byte_ff;
   assign rsp_group_last   = last_ff;
   assign rsp_message_end  = end_ff;
   assign rsp_length_error = lerr_ff;
   assign rsp_bad_char     = bad_ff;
   assign rsp_empty        = ~valid_ff;

endmodule

@@ rtl/core/b64d_checker.sv @@
`timescale 1ns / 1ps

module b64d_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_group_last,
   input logic       rsp_message_end,
   input logic       rsp_length_error
);

   // nothing waits on the result side and requests are open right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> (rsp_empty && !req_full))
      else $error("block not empty after reset");

   // an error result is a zero byte that closes the message
   a_error_form: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_length_error) |->
         (rsp_out_byte == 8'd0 && rsp_group_last && rsp_message_end))
      else $error("malformed length error result");

   // the end of a message is always the last byte of its group
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_message_end) |-> rsp_group_last)
      else $error("message end without group last");

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_byte)))
      else $error("stalled result changed");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_group_last   (rsp_group_last),
   .rsp_message_end  (rsp_message_end),
   .rsp_length_error (rsp_length_error)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

typedef struct packed {
   logic [7:0] data;
   logic       group_last;
   logic       message_end;
   logic       length_error;
   logic       bad_char;
} decoded_result_type;

class b64_decode_scoreboard;
   // Shadow of the decoder state
   logic [1:0]  position;
   logic [17:0] sextets;
   logic        third_pad;
   logic        bad_seen;
   decoded_result_type expected_bytes[$];
   int errors;

   function new();
      errors = 0;
      clear_group();
   endfunction

   function void clear_group();
      position  = 2'd0;
      sextets   = 18'd0;
      third_pad = 1'b0;
      bad_seen  = 1'b0;
   endfunction

   // 0..63 for alphabet characters, 64 for anything else
   function int sextet_value(logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 'h41;
      if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 'h61 + 26;
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30 + 52;
      if (c == 8'h2B) return 62;
      if (c == 8'h2F) return 63;
      return 64;
   endfunction

   function void push_expected(logic [7:0] data, logic glast, logic mend, logic lerr,
                               logic bad);
      decoded_result_type r;
      r.data         = data;
      r.group_last   = glast;
      r.message_end  = mend;
      r.length_error = lerr;
      r.bad_char     = bad;
      expected_bytes.push_back(r);
   endfunction

   function void note_request(logic [7:0] c, logic fin);
      logic        is_pad;
      int          value;
      logic [5:0]  sx;
      logic [23:0] triple;
      int          count;
      logic        last;
      is_pad = (c == b64d_pkg::PAD_CHAR);
      sx     = 6'd0;
      if (!is_pad) begin
         value = sextet_value(c);
         if (value == 64) begin
            bad_seen = 1'b1;
         end else begin
            sx = 6'(value);
         end
      end
      if (position != 2'd3) begin
         if (fin) begin
            push_expected(8'h00, 1'b1, 1'b1, 1'b1, bad_seen);
            clear_group();
            return;
         end
         sextets = {sextets[11:0], sx};
         if (position == 2'd2) third_pad = is_pad;
         position = position + 2'd1;
         return;
      end
      triple = {sextets, sx};
      count  = 3;
      if (fin) begin
         if (is_pad) count--;
         if (third_pad) count--;
      end
      for (int k = 0; k < count; k++) begin
         last = (k == count - 1);
         push_expected(triple[23 - 8 * k -: 8], last, last & fin, 1'b0, bad_seen);
      end
      clear_group();
   endfunction

   task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
   endtask

   task check_result(decoded_result_type got);
      decoded_result_type want;
      if (expected_bytes.size() == 0) begin
         report_mismatch($sformatf("unexpected result byte=%02h last=%0b end=%0b lerr=%0b bad=%0b",
                                   got.data, got.group_last, got.message_end,
                                   got.length_error, got.bad_char));
         return;
      end
      want = expected_bytes.pop_front();
      if (got.data !== want.data || got.group_last !== want.group_last ||
          got.message_end !== want.message_end || got.length_error !== want.length_error ||
          got.bad_char !== want.bad_char) begin
         report_mismatch($sformatf("got byte=%02h last=%0b end=%0b lerr=%0b bad=%0b, %s",
                                   got.data, got.group_last, got.message_end,
                                   got.length_error, got.bad_char,
                                   $sformatf("want byte=%02h last=%0b end=%0b lerr=%0b bad=%0b",
                                             want.data, want.group_last, want.message_end,
                                             want.length_error, want.bad_char)));
      end
   endtask

   function int pending();
      return expected_bytes.size();
   endfunction
endclass

module testbench;

   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_ITEMS  = 300;
   localparam int CALM_FROM     = 240;
   localparam int DRAIN_CYCLES  = 16;

   logic       clock;
   logic       reset            = 1'b1;
   logic       req_push         = 1'b0;
   logic       req_full;
   logic [7:0] req_in_char      = 8'h00;
   logic       req_final_char   = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop          = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_group_last;
   logic       rsp_message_end;
   logic       rsp_length_error;
   logic       rsp_bad_char;

   b64_decode_scoreboard sb = new();

   // Idle bursts on both sides while this is set; clear it for the calm tail
   bit idle_on = 1'b1;
   int item_count = 0;

   base64_stream_decoder i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_in_char      (req_in_char),
      .req_final_char   (req_final_char),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_group_last   (rsp_group_last),
      .rsp_message_end  (rsp_message_end),
      .rsp_length_error (rsp_length_error),
      .rsp_bad_char     (rsp_bad_char)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Push one character as a request; hold it until the block takes it.
   // Every call starts and ends just after a rising edge, so push is only
   // ever assigned once per time step.
   task push_char(logic [7:0] c, logic fin);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         // drop push for a random idle burst
         req_push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_push       <= 1'b1;
      req_in_char    <= c;
      req_final_char <= fin;
      do @(posedge clock); while (req_full);
      // Values read here are those seen at the edge, before the block updates
      sb.note_request(c, fin);
      item_count++;
   endtask

   task push_text(string s, bit fin_at_end);
      for (int i = 0; i < s.len(); i++) begin
         push_char(s[i], fin_at_end && (i == s.len() - 1));
      end
   endtask

   function automatic logic [7:0] alphabet_char();
      int unsigned v;
      v = $urandom_range(0, 63);
      if (v < 26) return 8'h41 + 8'(v);
      if (v < 52) return 8'h61 + 8'(v - 26);
      if (v < 62) return 8'h30 + 8'(v - 52);
      if (v == 62) return 8'h2B;
      return 8'h2F;
   endfunction

   // Mostly alphabet, now and then a pad or any byte at all
   function automatic logic [7:0] body_char();
      int unsigned r;
      r = $urandom_range(0, 31);
      if (r == 0) return 8'($urandom_range(0, 255));
      if (r == 1) return b64d_pkg::PAD_CHAR;
      return alphabet_char();
   endfunction

   // A message of whole groups; the last group takes one of four pad shapes
   task push_well_formed();
      int unsigned groups;
      int unsigned shape;
      logic [7:0]  third;
      logic [7:0]  fourth;
      groups = $urandom_range(0, 3);
      repeat (groups * 4) push_char(body_char(), 1'b0);
      shape  = $urandom_range(0, 3);
      third  = (shape == 2 || shape == 3) ? b64d_pkg::PAD_CHAR : body_char();
      fourth = (shape == 1 || shape == 2) ? b64d_pkg::PAD_CHAR : body_char();
      push_char(body_char(), 1'b0);
      push_char(body_char(), 1'b0);
      push_char(third, 1'b0);
      push_char(fourth, 1'b1);
   endtask

   // A message whose length leaves a partial group at the end
   task push_broken();
      int unsigned len;
      len = $urandom_range(1, 11);
      if (len % 4 == 0) len++;
      for (int unsigned i = 0; i < len; i++) push_char(body_char(), i == len - 1);
   endtask

   // Raw bytes of any value, in whole groups
   task push_noise();
      int unsigned len;
      len = 4 * $urandom_range(1, 2);
      for (int unsigned i = 0; i < len; i++) begin
         push_char(8'($urandom_range(0, 255)), i == len - 1);
      end
   endtask

   // Result side: pop in random bursts and check every accepted result
   initial begin
      int stall;
      decoded_result_type got;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            got.data         = rsp_out_byte;
            got.group_last   = rsp_group_last;
            got.message_end  = rsp_message_end;
            got.length_error = rsp_length_error;
            got.bad_char     = rsp_bad_char;
            sb.check_result(got);
         end
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            stall--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_pop <= 1'b0;
            stall = $urandom_range(0, 7);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Watchdog: give up after a long stretch with no handshake on either side
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet = 0;
         else quiet++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: the three final-group shapes, then the alphabet extremes
      push_text("TWFu", 1'b1);
      push_text("TWE=", 1'b1);
      push_text("TQ==", 1'b1);
      // Pad inside an earlier group still yields all three bytes
      push_text("+/z=", 1'b0);
      // Bytes outside the alphabet, low and high codes, flag the group
      push_text("9A", 1'b0);
      push_char(8'h00, 1'b0);
      push_char(8'hFF, 1'b1);
      // Third pad only: two bytes
      push_text("Z0=a", 1'b1);
      // Length errors: final on the first and on the second character
      push_char(8'h7A, 1'b1);
      push_text("Za", 1'b1);

      // Random messages; the last stretch runs with no idling at all
      while (item_count < RANDOM_ITEMS) begin
         int unsigned kind;
         if (item_count >= CALM_FROM) idle_on = 1'b0;
         kind = $urandom_range(0, 9);
         if (kind <= 6) push_well_formed();
         else if (kind <= 8) push_broken();
         else push_noise();
      end
      req_push <= 1'b0;

      // Drain every outstanding byte, then keep watching for strays
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
